// ===== rtl/ceq_pkg.sv =====
package ceq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PAYLOAD_BYTES = 32;
    localparam int PAY_WORDS     = 4;
    localparam int QA_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int CMDQ_DEPTH    = 2;
    localparam int CMDQ_AW       = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CW       = $clog2(CMDQ_DEPTH + 1);

    localparam logic [31:0] FLUSH_INTERVAL_RESET = 32'd1000;

    localparam logic [2:0] ST_QUEUED    = 3'd0;
    localparam logic [2:0] ST_COALESCED = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_REJECTED  = 3'd3;
    localparam logic [2:0] ST_FLUSHED   = 3'd4;
    localparam logic [2:0] ST_FINAL     = 3'd5;

    typedef enum logic [1:0] {
        OP_POST,
        OP_REJECT,
        OP_TICK
    } t_op;

    typedef struct packed {
        logic        req_type;
        logic [15:0] event_code;
        logic [31:0] event_detail;
        logic [31:0] event_transaction;
        logic [31:0] event_boot;
        logic [31:0] time_now;
        logic [63:0] payload_0;
        logic [63:0] payload_1;
        logic [63:0] payload_2;
        logic [63:0] payload_3;
        logic        drain_now;
        logic        sink_ready;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_code;
        logic [31:0] out_detail;
        logic [31:0] out_transaction;
        logic [31:0] out_boot;
        logic [63:0] out_payload_0;
        logic [63:0] out_payload_1;
        logic [63:0] out_payload_2;
        logic [63:0] out_payload_3;
        logic [31:0] repeat_count;
        logic [31:0] first_time;
        logic [31:0] last_time;
    } t_out_item;

    typedef struct packed {
        t_op                             op;
        logic [15:0]                     code;
        logic [31:0]                     detail;
        logic [31:0]                     transaction;
        logic [31:0]                     boot;
        logic [31:0]                     time_now;
        logic [PAY_WORDS-1:0][63:0]      payload;
        logic                            drain_now;
        logic                            sink_ready;
    } t_cmd;

    typedef struct packed {
        logic [15:0]                     code;
        logic [31:0]                     detail;
        logic [31:0]                     transaction;
        logic [31:0]                     boot;
        logic [PAY_WORDS-1:0][63:0]      payload;
        logic [31:0]                     repeat_cnt;
        logic [31:0]                     first_time;
        logic [31:0]                     last_time;
    } t_entry;

    function automatic logic [63:0] pay_mask(input int w);
        int avail;
        avail = PAYLOAD_BYTES - 8 * w;
        if (avail <= 0) begin
            return 64'd0;
        end
        if (avail >= 8) begin
            return {64{1'b1}};
        end
        return (64'd1 << (8 * avail)) - 64'd1;
    endfunction

endpackage

// ===== rtl/ceq_front.sv =====
module ceq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  ceq_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output ceq_pkg::t_cmd     o_cmd
);
    import ceq_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_full      = r_valid && !i_cmd_ready;
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // decode: tick, zero code rejected, otherwise post
    always_comb begin
        n_cmd             = '0;
        if (i_item.req_type) begin
            n_cmd.op = OP_TICK;
        end else if (i_item.event_code == 16'd0) begin
            n_cmd.op = OP_REJECT;
        end else begin
            n_cmd.op = OP_POST;
        end
        n_cmd.code        = i_item.event_code;
        n_cmd.detail      = i_item.event_detail;
        n_cmd.transaction = i_item.event_transaction;
        n_cmd.boot        = i_item.event_boot;
        n_cmd.time_now    = i_item.time_now;
        n_cmd.payload[0]  = i_item.payload_0 & pay_mask(0);
        n_cmd.payload[1]  = i_item.payload_1 & pay_mask(1);
        n_cmd.payload[2]  = i_item.payload_2 & pay_mask(2);
        n_cmd.payload[3]  = i_item.payload_3 & pay_mask(3);
        n_cmd.drain_now   = i_item.drain_now;
        n_cmd.sink_ready  = i_item.sink_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_cmd_ready);
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== rtl/ceq_cmd_fifo.sv =====
module ceq_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ceq_pkg::t_cmd i_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop,
    output ceq_pkg::t_cmd o_cmd
);
    import ceq_pkg::*;

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp;
    logic [CMDQ_AW-1:0] r_rp;
    logic [CMDQ_CW-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_push_ready = r_cnt != CMDQ_CW'(CMDQ_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_cmd        = r_mem[r_rp];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_wp + CMDQ_AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_rp + CMDQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CMDQ_CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CMDQ_CW'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== rtl/ceq_back.sv =====
module ceq_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    output logic                       o_cmd_pop,
    input  ceq_pkg::t_cmd              i_cmd,
    input  logic [31:0]                i_flush_interval,
    output logic                       o_empty,
    input  logic                       i_pop,
    output ceq_pkg::t_out_item         o_result,
    output logic [ceq_pkg::FILL_W-1:0] o_fill
);
    import ceq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLUSH_RD,
        S_FLUSH_OUT
    } t_state;

    t_entry            r_mem [QUEUE_DEPTH];
    t_entry            r_rd_data;
    logic [QA_W-1:0]   rd_addr;
    logic              mem_we;
    logic [QA_W-1:0]   mem_waddr;
    t_entry            mem_wdata;

    t_state            r_state, n_state;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [QA_W-1:0]   r_idx, n_idx;
    logic [31:0]       r_last_flush, n_last_flush;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;
    t_entry            r_tail, n_tail;

    logic              out_free;
    logic              same;
    logic              q_full;
    logic              do_flush;
    logic              last_entry;
    t_entry            upd;
    t_entry            fresh;
    logic [31:0]       elapsed;

    assign out_free = !r_out_valid || i_pop;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;
    assign o_fill   = r_fill;

    assign q_full  = r_fill == FILL_W'(QUEUE_DEPTH);
    assign elapsed = i_cmd.time_now - r_last_flush;
    assign do_flush = (r_fill != '0) && i_cmd.sink_ready &&
                      (i_cmd.drain_now || (elapsed >= i_flush_interval) || q_full);
    assign same = (r_fill != '0) &&
                  (r_tail.code == i_cmd.code) &&
                  (r_tail.detail == i_cmd.detail) &&
                  (r_tail.transaction == i_cmd.transaction) &&
                  (r_tail.boot == i_cmd.boot) &&
                  (r_tail.payload == i_cmd.payload);
    assign last_entry = FILL_W'(r_idx) == (r_fill - FILL_W'(1));

    always_comb begin
        upd            = r_tail;
        upd.repeat_cnt = (r_tail.repeat_cnt == {32{1'b1}}) ? r_tail.repeat_cnt
                                                          : r_tail.repeat_cnt + 32'd1;
        upd.last_time  = i_cmd.time_now;

        fresh             = '0;
        fresh.code        = i_cmd.code;
        fresh.detail      = i_cmd.detail;
        fresh.transaction = i_cmd.transaction;
        fresh.boot        = i_cmd.boot;
        fresh.payload     = i_cmd.payload;
        fresh.repeat_cnt  = 32'd1;
        fresh.first_time  = i_cmd.time_now;
        fresh.last_time   = i_cmd.time_now;
    end

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_idx        = r_idx;
        n_last_flush = r_last_flush;
        n_out_valid  = r_out_valid && !i_pop;
        n_out        = r_out;
        n_tail       = r_tail;
        mem_we       = 1'b0;
        mem_waddr    = QA_W'(r_fill);
        mem_wdata    = fresh;
        rd_addr      = r_idx;
        o_cmd_pop    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_REJECT: begin
                            n_out        = '0;
                            n_out.status = ST_REJECTED;
                            n_out_valid  = 1'b1;
                        end
                        OP_POST: begin
                            n_out       = '0;
                            n_out_valid = 1'b1;
                            if (same) begin
                                n_out.status = ST_COALESCED;
                                mem_we       = 1'b1;
                                mem_waddr    = QA_W'(r_fill - FILL_W'(1));
                                mem_wdata    = upd;
                                n_tail       = upd;
                            end else if (q_full) begin
                                n_out.status = ST_DROPPED;
                            end else begin
                                n_out.status = ST_QUEUED;
                                mem_we       = 1'b1;
                                n_tail       = fresh;
                                n_fill       = r_fill + FILL_W'(1);
                            end
                        end
                        OP_TICK: begin
                            if (do_flush) begin
                                n_last_flush = i_cmd.time_now;
                                n_idx        = '0;
                                n_state      = S_FLUSH_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FLUSH_RD: begin
                n_state = S_FLUSH_OUT;
            end
            S_FLUSH_OUT: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.status          = last_entry ? ST_FINAL : ST_FLUSHED;
                    n_out.out_code        = r_rd_data.code;
                    n_out.out_detail      = r_rd_data.detail;
                    n_out.out_transaction = r_rd_data.transaction;
                    n_out.out_boot        = r_rd_data.boot;
                    n_out.out_payload_0   = r_rd_data.payload[0];
                    n_out.out_payload_1   = r_rd_data.payload[1];
                    n_out.out_payload_2   = r_rd_data.payload[2];
                    n_out.out_payload_3   = r_rd_data.payload[3];
                    n_out.repeat_count    = r_rd_data.repeat_cnt;
                    n_out.first_time      = r_rd_data.first_time;
                    n_out.last_time       = r_rd_data.last_time;
                    if (last_entry) begin
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + QA_W'(1);
                        rd_addr = n_idx;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_idx        <= '0;
            r_last_flush <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fill       <= n_fill;
            r_idx        <= n_idx;
            r_last_flush <= n_last_flush;
            r_out_valid  <= n_out_valid;
        end
        r_out  <= n_out;
        r_tail <= n_tail;
    end

endmodule

// ===== rtl/coalescing_event_queue_top.sv =====
// channel   | dir | handshake               | payload
// ----------+-----+-------------------------+---------------------------
// item in   | in  | push / full             | i_item   (t_in_item)
// result    | out | empty / pop             | o_result (t_out_item)
// config    | in  | i_cfg_valid/o_cfg_ready | i_cfg_data (flush interval)
//
// A post or reject yields one result from the back end.
// A flush first reads the first entry from entry memory, then yields one
// entry per cycle while pop keeps up; the entry memory read port sets that pace.
// Synchronous active-low reset clears control; entry memory is not cleared.
// A two-entry command queue lets the input side keep taking items while
// the result side stalls; full rises once the queue and input stage fill.
module coalescing_event_queue_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  ceq_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output ceq_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    import ceq_pkg::*;

    logic              r_flush_interval;
    logic [31:0]       r_interval;
    logic              f_valid;
    logic              f_ready;
    t_cmd              f_cmd;
    logic              q_valid;
    logic              q_pop;
    t_cmd              q_cmd;
    logic [FILL_W-1:0] fill;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval       <= FLUSH_INTERVAL_RESET;
            r_flush_interval <= 1'b0;
        end else begin
            r_flush_interval <= i_cfg_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_interval <= i_cfg_data;
            end
        end
    end

    ceq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    ceq_cmd_fifo u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_cmd        (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_cmd        (q_cmd)
    );

    ceq_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (q_valid),
        .o_cmd_pop        (q_pop),
        .i_cmd            (q_cmd),
        .i_flush_interval (r_interval),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_result         (o_result),
        .o_fill           (fill)
    );

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= FILL_W'(QUEUE_DEPTH))
        else $error("fill level above queue depth");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result.status <= ST_FINAL)
        else $error("result status out of range");

    a_flush_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.status == ST_FLUSHED || o_result.status == ST_FINAL))
        |-> o_result.repeat_count != 32'd0)
        else $error("flushed entry with zero repeat count");

    a_post_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.status == ST_QUEUED || o_result.status == ST_COALESCED))
        |-> (o_result.out_code == 16'd0 && o_result.repeat_count == 32'd0))
        else $error("post result carries entry data");

    a_cfg_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush_interval |-> $past(i_cfg_valid))
        else $error("config write tracking mismatch");

endmodule

// ===== sim/coalescing_event_queue_top_tb.sv =====
`timescale 1ns / 1ps

module coalescing_event_queue_top_tb;
    import ceq_pkg::*;

    localparam logic REQ_POST         = 1'b0;
    localparam logic REQ_TICK         = 1'b1;
    localparam int   SETTLE_CYCLES    = 20;
    localparam int   RANDOM_PER_PHASE = 90;
    localparam int   N_PHASES         = 5;
    localparam int   REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [15:0]                code;
        logic [31:0]                detail;
        logic [31:0]                transaction;
        logic [31:0]                boot;
        logic [PAY_WORDS-1:0][63:0] payload;
        logic [31:0]                repeat_cnt;
        logic [31:0]                first_time;
        logic [31:0]                last_time;
    } t_slot;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    t_in_item    i_item      = '0;
    logic        empty;
    logic        pop         = 1'b0;
    t_out_item   o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data  = '0;

    coalescing_event_queue_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // mailbox state as the block should hold it
    t_slot       slots [QUEUE_DEPTH];
    int          fill_count    = 0;
    logic [31:0] last_flush_ms = '0;
    logic [31:0] interval_ms   = FLUSH_INTERVAL_RESET;

    t_out_item   due_reports [$];
    t_in_item    event_feed [$];
    bit          sending       = 1'b0;
    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;

    int          mismatches      = 0;
    int          reports_seen    = 0;
    int          posts_taken     = 0;
    int          ticks_taken     = 0;
    int          batches_flushed = 0;
    int          status_tally [8];

    logic [31:0] clock_ms    = '0;
    t_in_item    recent_post = '0;
    bit          have_recent = 1'b0;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item make_post(input logic [15:0] code,
                                           input logic [31:0] detail, trans, boot, now,
                                           input logic [63:0] p0, p1, p2, p3);
        t_in_item it;
        it.req_type          = REQ_POST;
        it.event_code        = code;
        it.event_detail      = detail;
        it.event_transaction = trans;
        it.event_boot        = boot;
        it.time_now          = now;
        it.payload_0         = p0;
        it.payload_1         = p1;
        it.payload_2         = p2;
        it.payload_3         = p3;
        it.drain_now         = ($urandom_range(0, 1) == 1);
        it.sink_ready        = ($urandom_range(0, 1) == 1);
        return it;
    endfunction

    // post fields carry noise on a tick
    function automatic t_in_item make_tick(input logic [31:0] now, input logic drain,
                                           input logic ready);
        t_in_item    it;
        logic [31:0] r;
        r = $urandom;
        it = make_post(r[15:0], $urandom, $urandom, $urandom, now,
                       rand64(), rand64(), rand64(), rand64());
        it.req_type   = REQ_TICK;
        it.drain_now  = drain;
        it.sink_ready = ready;
        return it;
    endfunction

    task automatic coalesce_or_flush(input t_in_item it);
        t_out_item                  rep;
        logic [PAY_WORDS-1:0][63:0] pay;
        logic [31:0]                since;
        int                         top;
        logic                       same;
        pay = {it.payload_3, it.payload_2, it.payload_1, it.payload_0};
        for (int w = 0; w < PAY_WORDS; w++) begin
            for (int b = 0; b < 8; b++) begin
                if (8 * w + b >= PAYLOAD_BYTES) begin
                    pay[w][8*b +: 8] = 8'h00;
                end
            end
        end
        rep = '0;
        if (it.req_type == REQ_POST) begin
            posts_taken++;
            same = 1'b0;
            if (it.event_code == 16'd0) begin
                rep.status = ST_REJECTED;
            end else begin
                if (fill_count > 0) begin
                    top  = fill_count - 1;
                    same = slots[top].code == it.event_code &&
                           slots[top].detail == it.event_detail &&
                           slots[top].transaction == it.event_transaction &&
                           slots[top].boot == it.event_boot &&
                           slots[top].payload == pay;
                    if (same) begin
                        if (slots[top].repeat_cnt != '1) begin
                            slots[top].repeat_cnt++;
                        end
                        slots[top].last_time = it.time_now;
                    end
                end
                if (same) begin
                    rep.status = ST_COALESCED;
                end else if (fill_count >= QUEUE_DEPTH) begin
                    rep.status = ST_DROPPED;
                end else begin
                    slots[fill_count].code        = it.event_code;
                    slots[fill_count].detail      = it.event_detail;
                    slots[fill_count].transaction = it.event_transaction;
                    slots[fill_count].boot        = it.event_boot;
                    slots[fill_count].payload     = pay;
                    slots[fill_count].repeat_cnt  = 32'd1;
                    slots[fill_count].first_time  = it.time_now;
                    slots[fill_count].last_time   = it.time_now;
                    fill_count++;
                    rep.status = ST_QUEUED;
                end
            end
            status_tally[rep.status]++;
            due_reports.push_back(rep);
        end else begin
            ticks_taken++;
            since = it.time_now - last_flush_ms;
            if (fill_count > 0 && it.sink_ready &&
                (it.drain_now || since >= interval_ms || fill_count >= QUEUE_DEPTH)) begin
                for (int k = 0; k < fill_count; k++) begin
                    rep.status          = (k == fill_count - 1) ? ST_FINAL : ST_FLUSHED;
                    rep.out_code        = slots[k].code;
                    rep.out_detail      = slots[k].detail;
                    rep.out_transaction = slots[k].transaction;
                    rep.out_boot        = slots[k].boot;
                    rep.out_payload_0   = slots[k].payload[0];
                    rep.out_payload_1   = slots[k].payload[1];
                    rep.out_payload_2   = slots[k].payload[2];
                    rep.out_payload_3   = slots[k].payload[3];
                    rep.repeat_count    = slots[k].repeat_cnt;
                    rep.first_time      = slots[k].first_time;
                    rep.last_time       = slots[k].last_time;
                    due_reports.push_back(rep);
                end
                fill_count    = 0;
                last_flush_ms = it.time_now;
                batches_flushed++;
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            end
        end
    endtask

    task automatic check_report(input t_out_item got);
        t_out_item want;
        reports_seen++;
        if (due_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: report with none due, status %0d", $time, got.status);
            end
        end else begin
            want = due_reports.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("out_code", want.out_code, got.out_code);
            compare_field("out_detail", want.out_detail, got.out_detail);
            compare_field("out_transaction", want.out_transaction, got.out_transaction);
            compare_field("out_boot", want.out_boot, got.out_boot);
            compare_field("out_payload_0", want.out_payload_0, got.out_payload_0);
            compare_field("out_payload_1", want.out_payload_1, got.out_payload_1);
            compare_field("out_payload_2", want.out_payload_2, got.out_payload_2);
            compare_field("out_payload_3", want.out_payload_3, got.out_payload_3);
            compare_field("repeat_count", want.repeat_count, got.repeat_count);
            compare_field("first_time", want.first_time, got.first_time);
            compare_field("last_time", want.last_time, got.last_time);
        end
    endtask

    // driver: a transfer is taken at the rising edge, the next item goes out at the falling edge
    always begin
        @(posedge i_clk);
        if (i_rst_n && push && !full) begin
            coalesce_or_flush(i_item);
            sending = 1'b0;
        end
        @(negedge i_clk);
        if (!sending) begin
            if (i_rst_n && event_feed.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                i_item  <= event_feed.pop_front();
                push    <= 1'b1;
                sending = 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    always begin
        @(posedge i_clk);
        if (i_rst_n && pop && !empty) begin
            check_report(o_result);
        end
        @(negedge i_clk);
        pop <= i_rst_n && ($urandom_range(0, 99) >= pop_stall_pct);
    end

    task automatic wait_quiet();
        do begin
            @(negedge i_clk);
        end while (event_feed.size() > 0 || sending || due_reports.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        interval_ms = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // expects a fresh mailbox with the reset interval
    task automatic queue_directed();
        t_in_item    ev;
        t_in_item    newest;
        logic [63:0] ones;
        ones = '1;
        event_feed.push_back(make_tick(32'd0, 1'b1, 1'b1));
        event_feed.push_back(make_post(16'd0, '1, '1, '1, '1, ones, ones, ones, ones));
        ev = make_post(16'hFFFF, '1, '1, '1, 32'd0, ones, ones, ones, ones);
        event_feed.push_back(ev);
        ev.time_now = '1;
        event_feed.push_back(ev);
        ev.payload_3 = 64'h7FFF_FFFF_FFFF_FFFF;
        ev.time_now  = 32'd10;
        event_feed.push_back(ev);
        event_feed.push_back(make_tick(32'd100, 1'b1, 1'b0));
        event_feed.push_back(make_tick(32'd999, 1'b0, 1'b1));
        event_feed.push_back(make_tick(32'd1000, 1'b0, 1'b1));
        newest = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            newest = make_post(16'h0100 + k[15:0], $urandom, $urandom, $urandom,
                               32'd1001 + k, rand64(), rand64(), rand64(), rand64());
            event_feed.push_back(newest);
        end
        event_feed.push_back(make_post(16'h0200, $urandom, $urandom, $urandom, 32'd1020,
                                       rand64(), rand64(), rand64(), rand64()));
        newest.time_now = 32'd1030;
        event_feed.push_back(newest);
        event_feed.push_back(make_tick(32'd1100, 1'b0, 1'b1));
        event_feed.push_back(make_post(16'h0300, '0, '0, '0, 32'd1200, '0, '0, '0, '0));
        // time behind the last flush: elapsed time wraps around
        event_feed.push_back(make_tick(32'd50, 1'b0, 1'b1));
    endtask

    // mostly runs of repeats and fresh events, with ticks, rejects and near-duplicates
    task automatic queue_random(input int n);
        t_in_item    ev;
        int          roll;
        logic [31:0] r;
        int          pos;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) begin
                clock_ms = $urandom;
            end else begin
                clock_ms = clock_ms + $urandom_range(0, 400);
            end
            if (roll < 15) begin
                ev = make_tick(clock_ms, $urandom_range(0, 3) == 0, $urandom_range(0, 4) != 0);
            end else if (roll < 20) begin
                ev = make_post(16'd0, $urandom, $urandom, $urandom, clock_ms,
                               rand64(), rand64(), rand64(), rand64());
            end else if (roll < 55 && have_recent) begin
                ev = recent_post;
                ev.time_now   = clock_ms;
                ev.drain_now  = ($urandom_range(0, 1) == 1);
                ev.sink_ready = ($urandom_range(0, 1) == 1);
                if ($urandom_range(0, 9) == 0) begin
                    pos = $urandom_range(0, 63);
                    ev.payload_2[pos] = ~ev.payload_2[pos];
                end
                recent_post = ev;
            end else begin
                r = $urandom;
                ev = make_post(r[16] ? (r[15:0] | 16'h0001) : ({13'd0, r[2:0]} + 16'd1),
                               $urandom, $urandom, $urandom, clock_ms,
                               rand64(), rand64(), rand64(), rand64());
                recent_post = ev;
                have_recent = 1'b1;
            end
            event_feed.push_back(ev);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                wait_quiet();
            end
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    pop_stall_pct = 0;
                    write_interval(FLUSH_INTERVAL_RESET);
                    queue_directed();
                end
                1: begin
                    send_idle_pct = 65;
                    pop_stall_pct = 0;
                    write_interval(32'd0);
                end
                2: begin
                    send_idle_pct = 0;
                    pop_stall_pct = 65;
                    write_interval('1);
                end
                3: begin
                    send_idle_pct = 15;
                    pop_stall_pct = 15;
                    write_interval($urandom_range(1, 3000));
                end
                default: begin
                    send_idle_pct = 0;
                    pop_stall_pct = 0;
                    write_interval(32'd1);
                end
            endcase
            queue_random(RANDOM_PER_PHASE);
        end
        wait_quiet();
        $display("Sent %0d posts and %0d ticks across %0d flush intervals and idle patterns.",
                 posts_taken, ticks_taken, N_PHASES);
        $display("Reports %0d: %0d queued, %0d coalesced, %0d dropped, %0d rejected; %0d flushes.",
                 reports_seen, status_tally[ST_QUEUED], status_tally[ST_COALESCED],
                 status_tally[ST_DROPPED], status_tally[ST_REJECTED], batches_flushed);
        if (mismatches == 0 && due_reports.size() == 0) begin
            $display("coalescing_event_queue_top test passed");
        end else begin
            $display("coalescing_event_queue_top test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("coalescing_event_queue_top test failed");
        $finish;
    end

endmodule
